### rtl/swmt_pkg.sv
package swmt_pkg;

    localparam int KEY_W   = 64;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;

    typedef struct packed {
        logic [KEY_W-1:0] word_key;
        logic             new_set;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0]   mode_key;
        logic [COUNT_W-1:0] mode_count;
    } t_out_word;

    // one-cycle commands broadcast to every cell
    typedef struct packed {
        logic clear;
        logic evict;
        logic lookup;
        logic count;
    } t_cell_ctrl;

endpackage

### rtl/sliding_window_mode_tracker.sv
// Sliding-window mode tracker.
// Input channel: i_in_valid / o_in_stall carry one word (word_key, new_set).
// A word is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one word per input word:
// the most frequent key of the last window_size keys (smallest key on a tie)
// and its count. Write window_size through i_cfg_we / i_cfg_data while idle;
// zero acts as one, values above WINDOW_MAX act as WINDOW_MAX.
// From acceptance to a loaded output register an item passes S_CHECK, then
// S_EVICT and S_CHECK again for each eviction (one once the window is full,
// more after the window size was lowered), then S_LOOKUP, S_COUNT, S_REDUCE
// while the registered max tree settles, and S_DONE. The max tree has
// ceil(log2(WINDOW_MAX)/2) register stages (3 at WINDOW_MAX = 64). Each eviction
// costs one read of the window memory and one broadcast to the cell row.
// The next word is taken in the same cycle the result loads into the output
// register, so a waiting result does not block the input until the next one
// is finished. While the receiver stalls, the output word holds.
// Reset (synchronous, i_rst_n low) empties the window, frees all cells and
// sets window_size to 1; no clearing pass is needed.
module sliding_window_mode_tracker #(
    parameter int WINDOW_MAX = 64,
    parameter int KEY_BITS   = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  swmt_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output swmt_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [swmt_pkg::CFG_W-1:0]     i_cfg_data
);
    import swmt_pkg::*;

    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W  = $clog2(WINDOW_MAX);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int LEVELS  = $clog2(WINDOW_MAX);
    localparam int STAGES  = (LEVELS + 1) / 2;
    localparam int WAIT_W  = $clog2(STAGES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EVICT,
        S_LOOKUP,
        S_COUNT,
        S_REDUCE,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [WAIT_W-1:0]   r_wait;
    logic [CFG_W-1:0]    r_win_size;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_fill;
    logic [SLOT_W-1:0]   r_oldest;
    logic                r_out_valid;
    t_out_word           r_out_word;

    // window memory: circular buffer of keys, read port follows the oldest slot
    logic [KEY_BITS-1:0] r_win_mem [WINDOW_MAX];
    logic [KEY_BITS-1:0] r_rd_data;

    logic                w_in_accept;
    logic                w_out_free;
    logic                w_need_evict;
    logic [CMP_W-1:0]    w_size;
    logic [CMP_W-1:0]    w_cfg_ext;
    logic [SUM_W-1:0]    w_wr_sum;
    logic [SLOT_W-1:0]   w_wr_slot;
    logic [SLOT_W-1:0]   w_oldest_inc;
    logic [KEY_BITS-1:0] w_bcast_key;
    t_cell_ctrl          w_ctrl;
    logic                w_any_hit;

    logic [WINDOW_MAX-1:0] w_hit;
    logic [WINDOW_MAX-1:0] w_hole;
    logic                  w_cell_valid [WINDOW_MAX];
    logic [KEY_BITS-1:0]   w_cell_key   [WINDOW_MAX];
    logic [CNT_W-1:0]      w_cell_count [WINDOW_MAX];
    logic [KEY_BITS-1:0]   w_mode_key;
    logic [CNT_W-1:0]      w_mode_count;

    // output register can load when empty or when its word leaves this cycle
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) || ((r_state == S_DONE) && w_out_free));
    assign w_in_accept = i_in_valid && !o_in_stall;

    // clamp window size into 1..WINDOW_MAX
    assign w_cfg_ext = CMP_W'(r_win_size);
    always_comb begin
        if (r_win_size == '0) begin
            w_size = CMP_W'(1);
        end else if (w_cfg_ext > CMP_W'(WINDOW_MAX)) begin
            w_size = CMP_W'(WINDOW_MAX);
        end else begin
            w_size = w_cfg_ext;
        end
    end
    assign w_need_evict = (CMP_W'(r_fill) >= w_size);

    // slot of the new key: oldest + fill, wrapped (fill stays below WINDOW_MAX here)
    assign w_wr_sum  = SUM_W'(r_oldest) + SUM_W'(r_fill);
    assign w_wr_slot = (w_wr_sum >= SUM_W'(WINDOW_MAX)) ?
                       SLOT_W'(w_wr_sum - SUM_W'(WINDOW_MAX)) : SLOT_W'(w_wr_sum);
    assign w_oldest_inc = (r_oldest == SLOT_W'(WINDOW_MAX - 1)) ?
                          '0 : r_oldest + SLOT_W'(1);

    assign w_ctrl.clear  = w_in_accept && i_in_word.new_set;
    assign w_ctrl.evict  = (r_state == S_EVICT);
    assign w_ctrl.lookup = (r_state == S_LOOKUP);
    assign w_ctrl.count  = (r_state == S_COUNT);

    // evictions broadcast the oldest key, everything else the new one
    assign w_bcast_key = (r_state == S_EVICT) ? r_rd_data : r_key;
    assign w_any_hit   = |w_hit;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOKUP) begin
            r_win_mem[w_wr_slot] <= r_key;
        end
        r_rd_data <= r_win_mem[r_oldest];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_win_size  <= CFG_W'(1);
            r_fill      <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win_size <= i_cfg_data;
            end

            // drop the output word once taken; a new load below overrides
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                end
                S_CHECK: begin
                    r_state <= w_need_evict ? S_EVICT : S_LOOKUP;
                end
                S_EVICT: begin
                    r_oldest <= w_oldest_inc;
                    r_fill   <= r_fill - CNT_W'(1);
                    r_state  <= S_CHECK;
                end
                S_LOOKUP: begin
                    r_fill  <= r_fill + CNT_W'(1);
                    r_state <= S_COUNT;
                end
                S_COUNT: begin
                    r_wait  <= '0;
                    r_state <= S_REDUCE;
                end
                S_REDUCE: begin
                    if (r_wait == WAIT_W'(STAGES - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_wait <= r_wait + WAIT_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_word.mode_key   <= KEY_W'(w_mode_key);
                        r_out_word.mode_count <= COUNT_W'(w_mode_count);
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // take the next word; new_set empties the window first
            if (w_in_accept) begin
                r_key   <= i_in_word.word_key[KEY_BITS-1:0];
                r_state <= S_CHECK;
                if (i_in_word.new_set) begin
                    r_fill   <= '0;
                    r_oldest <= '0;
                end
            end
        end
    end

    // row of count cells; the free-slot chain runs from cell 0 upward
    assign w_hole[0] = 1'b0;
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        if (i < WINDOW_MAX - 1) begin : g_mid
            swmt_cell #(
                .KEY_BITS (KEY_BITS),
                .CNT_W    (CNT_W)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_key     (w_bcast_key),
                .i_any_hit (w_any_hit),
                .i_hole    (w_hole[i]),
                .o_hole    (w_hole[i+1]),
                .o_hit     (w_hit[i]),
                .o_valid   (w_cell_valid[i]),
                .o_key     (w_cell_key[i]),
                .o_count   (w_cell_count[i])
            );
        end else begin : g_end
            swmt_cell #(
                .KEY_BITS (KEY_BITS),
                .CNT_W    (CNT_W)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_key     (w_bcast_key),
                .i_any_hit (w_any_hit),
                .i_hole    (w_hole[i]),
                .o_hole    (),
                .o_hit     (w_hit[i]),
                .o_valid   (w_cell_valid[i]),
                .o_key     (w_cell_key[i]),
                .o_count   (w_cell_count[i])
            );
        end
    end

    swmt_tree #(
        .N_CELLS  (WINDOW_MAX),
        .KEY_BITS (KEY_BITS),
        .CNT_W    (CNT_W)
    ) u_tree (
        .i_clk   (i_clk),
        .i_valid (w_cell_valid),
        .i_key   (w_cell_key),
        .i_count (w_cell_count),
        .o_key   (w_mode_key),
        .o_count (w_mode_count)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### rtl/swmt_cell.sv
module swmt_cell #(
    parameter int KEY_BITS = 64,
    parameter int CNT_W    = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swmt_pkg::t_cell_ctrl i_ctrl,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_any_hit,
    input  logic                i_hole,
    output logic                o_hole,
    output logic                o_hit,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output logic [CNT_W-1:0]    o_count
);
    import swmt_pkg::*;

    logic                r_valid;
    logic                r_hit;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic                w_match;
    logic                w_alloc;
    logic                w_last;

    assign w_match = r_valid && (r_key == i_key);
    // first free cell of the chain takes a key that no cell holds
    assign w_alloc = !r_valid && !i_hole && !i_any_hit;
    assign w_last  = (r_count == CNT_W'(1));
    assign o_hole  = i_hole || !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.evict && w_match && w_last) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.count && w_alloc) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.lookup) begin
            r_hit <= w_match;
        end
        if (i_ctrl.evict && w_match) begin
            r_count <= r_count - CNT_W'(1);
        end else if (i_ctrl.count) begin
            if (i_any_hit && r_hit) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_alloc) begin
                r_key   <= i_key;
                r_count <= CNT_W'(1);
            end
        end
    end

    assign o_hit   = r_hit;
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_count = r_count;

endmodule

### rtl/swmt_tree.sv
module swmt_tree #(
    parameter int N_CELLS  = 64,
    parameter int KEY_BITS = 64,
    parameter int CNT_W    = 7
) (
    input  logic                i_clk,
    input  logic                i_valid [N_CELLS],
    input  logic [KEY_BITS-1:0] i_key   [N_CELLS],
    input  logic [CNT_W-1:0]    i_count [N_CELLS],
    output logic [KEY_BITS-1:0] o_key,
    output logic [CNT_W-1:0]    o_count
);

    localparam int LEVELS = $clog2(N_CELLS);
    localparam int LEAVES = 1 << LEVELS;

    typedef struct packed {
        logic                valid;
        logic [CNT_W-1:0]    count;
        logic [KEY_BITS-1:0] key;
    } t_cand;

    // higher count wins, smaller key on a tie, empty loses
    function automatic t_cand f_pick(input t_cand a, input t_cand b);
        logic a_wins;
        a_wins = a.valid && (!b.valid || (a.count > b.count) ||
                 ((a.count == b.count) && (a.key < b.key)));
        return a_wins ? a : b;
    endfunction

    // heap order: node n has children 2n and 2n+1, leaves from LEAVES up
    t_cand node [1:2*LEAVES-1];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < N_CELLS) begin : g_used
            assign node[LEAVES+i] = '{valid: i_valid[i], count: i_count[i], key: i_key[i]};
        end else begin : g_pad
            assign node[LEAVES+i] = '{valid: 1'b0, count: '0, key: '0};
        end
    end

    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        localparam int DEPTH  = $clog2(n + 1) - 1;
        localparam int HEIGHT = LEVELS - DEPTH;
        t_cand w_pick;
        assign w_pick = f_pick(node[2*n], node[2*n+1]);
        // register every second level and the root
        if ((HEIGHT % 2 == 0) || (n == 1)) begin : g_reg
            t_cand r_pick;
            always_ff @(posedge i_clk) begin
                r_pick <= w_pick;
            end
            assign node[n] = r_pick;
        end else begin : g_comb
            assign node[n] = w_pick;
        end
    end

    assign o_key   = node[1].key;
    assign o_count = node[1].count;

endmodule
